@@ rtl/core/soa_pkg.sv @@
// soa_pkg: types and constants shared by the slab object allocator.
// No dependencies.
`timescale 1ns / 1ps

package soa_pkg;

    localparam int SLABS     = 16;
    localparam int SLOTS     = 64;
    localparam int SLAB_W    = 4;
    localparam int SLOT_W    = 6;
    localparam int CNT_W     = 7;
    localparam int ADDR_W    = SLAB_W + SLOT_W;
    localparam int REL_W     = 5;
    localparam logic [CNT_W-1:0] END_MARK = CNT_W'(SLOTS);

    typedef enum logic [1:0] {
        FR_UNOWNED = 2'd0,
        FR_EMPTY   = 2'd1,
        FR_PARTIAL = 2'd2,
        FR_FULL    = 2'd3
    } frame_st_t;

    typedef enum logic [1:0] {
        REQ_ALLOC  = 2'd0,
        REQ_FREE   = 2'd1,
        REQ_SHRINK = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMEM   = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SEL,
        S_BUILD,
        S_POP_RD,
        S_POP_UPD,
        S_FREE,
        S_SHRINK,
        S_TOUCH,
        S_DONE
    } fsm_t;

endpackage

@@ rtl/core/soa_ram.sv @@
// soa_ram: generic single write, single read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module soa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/slab_object_allocator.sv @@
// slab_object_allocator: top level, request sequencer and frame tables.
// Depends on soa_pkg and soa_ram (free-list store).
//
//  channel   signals                                   handshake
//  request   req_type obj_slab obj_slot                start & !busy
//  result    status slab_index slot_index released_count  done, one cycle
//  config    cfg_wdata                                 cfg_we
//
// Allocate: frame scan, select, list build (objects_per_slab entries) when a new
// frame is claimed, pop read, pop update, recency update, result. Free: free,
// recency update, result; invalid free: free, result. Shrink: scan, result. Other
// codes: result. The frame scans and the recency list walk one entry per cycle.
// Reset leaves all frames unowned; the free-list store needs no clearing.
// busy stays high until the result cycle ends; results cannot be stalled.
`timescale 1ns / 1ps

module slab_object_allocator (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    output logic                      done,
    input  logic [1:0]                req_type,
    input  logic [soa_pkg::SLAB_W-1:0] obj_slab,
    input  logic [soa_pkg::SLOT_W-1:0] obj_slot,
    output logic [1:0]                status,
    output logic [soa_pkg::SLAB_W-1:0] slab_index,
    output logic [soa_pkg::SLOT_W-1:0] slot_index,
    output logic [soa_pkg::REL_W-1:0]  released_count,
    input  logic                      cfg_we,
    input  logic [soa_pkg::CNT_W-1:0]  cfg_wdata
);

    import soa_pkg::*;

    fsm_t state_reg, state_next;

    frame_st_t         fst_reg   [SLABS];
    frame_st_t         fst_next  [SLABS];
    logic [SLAB_W-1:0] order_reg [SLABS];
    logic [SLAB_W-1:0] order_next[SLABS];
    logic [CNT_W-1:0]  used_reg  [SLABS];
    logic [CNT_W-1:0]  used_next [SLABS];
    logic [CNT_W-1:0]  head_reg  [SLABS];
    logic [CNT_W-1:0]  head_next [SLABS];

    logic [CNT_W-1:0]  ops_reg, ops_next;
    logic [SLAB_W-1:0] fr_reg, fr_next;
    logic [SLOT_W-1:0] sl_reg, sl_next;
    logic [SLOT_W:0]   cnt_reg, cnt_next;
    logic [SLAB_W-1:0] hold_reg, hold_next;
    logic              pf_reg, pf_next, ef_reg, ef_next, uf_reg, uf_next;
    logic [SLAB_W-1:0] pfr_reg, pfr_next, efr_reg, efr_next, ufr_reg, ufr_next;
    logic [1:0]        st_reg, st_next;
    logic [SLAB_W-1:0] ob_reg, ob_next;
    logic [SLOT_W-1:0] os_reg, os_next;
    logic [REL_W-1:0]  rel_reg, rel_next;

    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [CNT_W-1:0]  wdata, rdata;
    logic [CNT_W-1:0]  n_eff;
    logic [SLAB_W-1:0] pidx, scan_f;
    logic [CNT_W-1:0]  nused;

    soa_ram #(.WIDTH(CNT_W), .DEPTH(SLABS * SLOTS)) u_list (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        if (ops_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (ops_reg > END_MARK)
        begin
            n_eff = END_MARK;
        end
        else
        begin
            n_eff = ops_reg;
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = (state_reg == S_DONE);
    assign status         = st_reg;
    assign slab_index     = ob_reg;
    assign slot_index     = os_reg;
    assign released_count = rel_reg;
    assign pidx           = cnt_reg[SLAB_W-1:0];
    assign scan_f         = order_reg[pidx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ops_reg   <= END_MARK;
            for (int i = 0; i < SLABS; i++)
            begin
                fst_reg[i]   <= FR_UNOWNED;
                order_reg[i] <= SLAB_W'(i);
                used_reg[i]  <= '0;
                head_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            ops_reg   <= ops_next;
            fst_reg   <= fst_next;
            order_reg <= order_next;
            used_reg  <= used_next;
            head_reg  <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fr_reg   <= fr_next;
        sl_reg   <= sl_next;
        cnt_reg  <= cnt_next;
        hold_reg <= hold_next;
        pf_reg   <= pf_next;
        ef_reg   <= ef_next;
        uf_reg   <= uf_next;
        pfr_reg  <= pfr_next;
        efr_reg  <= efr_next;
        ufr_reg  <= ufr_next;
        st_reg   <= st_next;
        ob_reg   <= ob_next;
        os_reg   <= os_next;
        rel_reg  <= rel_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ops_next   = cfg_we ? cfg_wdata : ops_reg;
        fst_next   = fst_reg;
        order_next = order_reg;
        used_next  = used_reg;
        head_next  = head_reg;
        fr_next    = fr_reg;
        sl_next    = sl_reg;
        cnt_next   = cnt_reg;
        hold_next  = hold_reg;
        pf_next    = pf_reg;
        ef_next    = ef_reg;
        uf_next    = uf_reg;
        pfr_next   = pfr_reg;
        efr_next   = efr_reg;
        ufr_next   = ufr_reg;
        st_next    = st_reg;
        ob_next    = ob_reg;
        os_next    = os_reg;
        rel_next   = rel_reg;
        we         = 1'b0;
        waddr      = {fr_reg, cnt_reg[SLOT_W-1:0]};
        wdata      = '0;
        raddr      = {fr_reg, head_reg[fr_reg][SLOT_W-1:0]};
        nused      = used_reg[fr_reg] + CNT_W'(1);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    fr_next  = obj_slab;
                    sl_next  = obj_slot;
                    cnt_next = '0;
                    pf_next  = 1'b0;
                    ef_next  = 1'b0;
                    uf_next  = 1'b0;
                    st_next  = ST_OK;
                    ob_next  = '0;
                    os_next  = '0;
                    rel_next = '0;
                    unique case (req_t'(req_type))
                        REQ_ALLOC:  state_next = S_SCAN;
                        REQ_FREE:   state_next = S_FREE;
                        REQ_SHRINK: state_next = S_SHRINK;
                        REQ_NONE:   state_next = S_DONE;
                    endcase
                end
            end

            S_SCAN:
            begin
                if (!pf_reg && fst_reg[scan_f] == FR_PARTIAL && head_reg[scan_f] < END_MARK)
                begin
                    pf_next  = 1'b1;
                    pfr_next = scan_f;
                end
                if (!ef_reg && fst_reg[scan_f] == FR_EMPTY && head_reg[scan_f] < END_MARK)
                begin
                    ef_next  = 1'b1;
                    efr_next = scan_f;
                end
                if (!uf_reg && fst_reg[pidx] == FR_UNOWNED)
                begin
                    uf_next  = 1'b1;
                    ufr_next = pidx;
                end
                cnt_next = cnt_reg + 1'b1;
                if (pidx == SLAB_W'(SLABS - 1))
                begin
                    state_next = S_SEL;
                end
            end

            S_SEL:
            begin
                cnt_next = '0;
                priority if (pf_reg)
                begin
                    fr_next    = pfr_reg;
                    state_next = S_POP_RD;
                end
                else if (ef_reg)
                begin
                    fr_next    = efr_reg;
                    state_next = S_POP_RD;
                end
                else if (uf_reg)
                begin
                    fr_next    = ufr_reg;
                    state_next = S_BUILD;
                end
                else
                begin
                    st_next    = ST_NOMEM;
                    state_next = S_DONE;
                end
            end

            S_BUILD:
            begin
                we = 1'b1;
                if (CNT_W'(cnt_reg) + CNT_W'(1) < n_eff)
                begin
                    wdata = CNT_W'(cnt_reg) + CNT_W'(1);
                end
                else
                begin
                    wdata      = END_MARK;
                    head_next[fr_reg] = '0;
                    used_next[fr_reg] = '0;
                    fst_next[fr_reg]  = FR_EMPTY;
                    state_next = S_POP_RD;
                end
                cnt_next = cnt_reg + 1'b1;
            end

            S_POP_RD:
            begin
                state_next = S_POP_UPD;
            end

            S_POP_UPD:
            begin
                os_next = head_reg[fr_reg][SLOT_W-1:0];
                ob_next = fr_reg;
                head_next[fr_reg] = rdata;
                used_next[fr_reg] = nused;
                fst_next[fr_reg]  = (nused >= n_eff || rdata >= END_MARK) ? FR_FULL
                                                                          : FR_PARTIAL;
                cnt_next   = '0;
                hold_next  = fr_reg;
                state_next = S_TOUCH;
            end

            S_FREE:
            begin
                if (CNT_W'(sl_reg) >= n_eff ||
                    (fst_reg[fr_reg] != FR_PARTIAL && fst_reg[fr_reg] != FR_FULL))
                begin
                    st_next    = ST_BADFREE;
                    state_next = S_DONE;
                end
                else
                begin
                    we    = 1'b1;
                    waddr = {fr_reg, sl_reg};
                    wdata = head_reg[fr_reg];
                    head_next[fr_reg] = CNT_W'(sl_reg);
                    if (used_reg[fr_reg] > '0)
                    begin
                        used_next[fr_reg] = used_reg[fr_reg] - CNT_W'(1);
                    end
                    fst_next[fr_reg] = (used_reg[fr_reg] <= CNT_W'(1)) ? FR_EMPTY
                                                                       : FR_PARTIAL;
                    cnt_next   = '0;
                    hold_next  = fr_reg;
                    state_next = S_TOUCH;
                end
            end

            S_SHRINK:
            begin
                if (fst_reg[pidx] == FR_EMPTY)
                begin
                    fst_next[pidx]  = FR_UNOWNED;
                    used_next[pidx] = '0;
                    head_next[pidx] = '0;
                    rel_next        = rel_reg + REL_W'(1);
                end
                cnt_next = cnt_reg + 1'b1;
                if (pidx == SLAB_W'(SLABS - 1))
                begin
                    state_next = S_DONE;
                end
            end

            S_TOUCH:
            begin
                order_next[pidx] = hold_reg;
                hold_next        = scan_f;
                cnt_next         = cnt_reg + 1'b1;
                if (scan_f == fr_reg || pidx == SLAB_W'(SLABS - 1))
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ verif/testbench.sv @@
// testbench: self-checking bench for slab_object_allocator with a built-in allocator predictor.
// Depends on soa_pkg and the slab_object_allocator RTL.
// Drives requests from a queue with random gaps and compares each done word with the prediction.
`timescale 1ns / 1ps

module testbench;
    import soa_pkg::*;

    typedef struct packed {
        logic       is_cfg;
        logic       live;
        logic [6:0] cfg_val;
        logic [1:0] req;
        logic [3:0] fslab;
        logic [5:0] fslot;
    } cmd_t;

    typedef struct packed {
        logic [1:0] st;
        logic [3:0] slab;
        logic [5:0] slot;
        logic [4:0] rel;
    } result_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    logic [1:0] req_type;
    logic [SLAB_W-1:0] obj_slab;
    logic [SLOT_W-1:0] obj_slot;
    logic [1:0] status;
    logic [SLAB_W-1:0] slab_index;
    logic [SLOT_W-1:0] slot_index;
    logic [REL_W-1:0] released_count;
    logic cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    slab_object_allocator dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .req_type(req_type), .obj_slab(obj_slab), .obj_slot(obj_slot),
        .status(status), .slab_index(slab_index), .slot_index(slot_index),
        .released_count(released_count), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // predictor state
    frame_st_t  m_state [SLABS];
    logic [3:0] m_recent [SLABS];
    int         m_used [SLABS];
    int         m_head [SLABS];
    int         m_link [SLABS*SLOTS];
    logic [6:0] m_opslab;

    cmd_t    pending_cmds [$];
    result_t expected_words [$];
    int      errors;
    int      idle_cycles;
    int      gap;
    bit      stim_done;
    // slots currently handed out, for well-formed frees
    int      live_objs [$];

    task automatic report_mismatch(input string what);
        errors++;
        $display("ERROR %0t: %s", $realtime, what);
    endtask

    function automatic int eff_slots();
        if (m_opslab == 0) return 1;
        if (m_opslab > SLOTS) return SLOTS;
        return m_opslab;
    endfunction

    function automatic void move_to_front(int f);
        int p;
        p = 0;
        while (p < SLABS && m_recent[p] != f) p++;
        if (p >= SLABS) p = SLABS - 1;
        for (int i = p; i > 0; i--) m_recent[i] = m_recent[i-1];
        m_recent[0] = f[3:0];
    endfunction

    function automatic int most_recent(frame_st_t st);
        for (int p = 0; p < SLABS; p++)
            if (m_state[m_recent[p]] == st && m_head[m_recent[p]] < SLOTS)
                return m_recent[p];
        return -1;
    endfunction

    function automatic result_t predict_request(cmd_t c);
        result_t r;
        int n, pick, s, f;
        r = '0;
        n = eff_slots();
        case (req_t'(c.req))
            REQ_ALLOC: begin
                pick = most_recent(FR_PARTIAL);
                if (pick < 0) pick = most_recent(FR_EMPTY);
                if (pick < 0) begin
                    for (f = 0; f < SLABS; f++) begin
                        if (m_state[f] == FR_UNOWNED) begin
                            for (s = 0; s < n; s++)
                                m_link[f*SLOTS+s] = (s + 1 < n) ? s + 1 : SLOTS;
                            m_head[f] = 0;
                            m_used[f] = 0;
                            m_state[f] = FR_EMPTY;
                            pick = f;
                            break;
                        end
                    end
                end
                if (pick < 0) begin
                    r.st = ST_NOMEM;
                end else begin
                    s = m_head[pick];
                    m_head[pick] = m_link[pick*SLOTS+s];
                    m_used[pick]++;
                    m_state[pick] = (m_used[pick] >= n || m_head[pick] >= SLOTS)
                        ? FR_FULL : FR_PARTIAL;
                    move_to_front(pick);
                    r.slab = pick[3:0];
                    r.slot = s[5:0];
                    live_objs.push_back(pick * SLOTS + s);
                end
            end
            REQ_FREE: begin
                f = c.fslab;
                s = c.fslot;
                if (s >= n || (m_state[f] != FR_PARTIAL && m_state[f] != FR_FULL)) begin
                    r.st = ST_BADFREE;
                end else begin
                    m_link[f*SLOTS+s] = m_head[f];
                    m_head[f] = s;
                    if (m_used[f] > 0) m_used[f]--;
                    m_state[f] = (m_used[f] == 0) ? FR_EMPTY : FR_PARTIAL;
                    move_to_front(f);
                end
            end
            REQ_SHRINK: begin
                for (f = 0; f < SLABS; f++) begin
                    if (m_state[f] == FR_EMPTY) begin
                        m_state[f] = FR_UNOWNED;
                        m_used[f] = 0;
                        m_head[f] = 0;
                        r.rel++;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic cmd_t mk_req(req_t t, int sl, int so);
        cmd_t c;
        c = '0;
        c.req = t;
        c.fslab = sl[3:0];
        c.fslot = so[5:0];
        return c;
    endfunction

    function automatic cmd_t mk_cfg(int v);
        cmd_t c;
        c = '0;
        c.is_cfg = 1'b1;
        c.cfg_val = v[6:0];
        return c;
    endfunction

    function automatic int rand_gap();
        if ($urandom_range(0, 9) < 4) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // stimulus: the driver hands out frees of live objects, so only the shape is queued here
    initial
    begin
        int cfgs [6];
        int idx;
        cmd_t lc;
        cfgs = '{1, 64, 3, 127, 0, 9};
        // directed: extremes and special cases
        pending_cmds.push_back(mk_req(REQ_FREE, 0, 0));
        pending_cmds.push_back(mk_req(REQ_ALLOC, 0, 0));
        pending_cmds.push_back(mk_req(REQ_ALLOC, 0, 0));
        pending_cmds.push_back(mk_req(REQ_FREE, 0, 63));
        pending_cmds.push_back(mk_req(REQ_FREE, 15, 0));
        pending_cmds.push_back(mk_req(REQ_FREE, 0, 1));
        pending_cmds.push_back(mk_req(REQ_FREE, 0, 1));
        pending_cmds.push_back(mk_req(REQ_FREE, 0, 0));
        pending_cmds.push_back(mk_req(REQ_NONE, 15, 63));
        pending_cmds.push_back(mk_req(REQ_SHRINK, 0, 0));
        pending_cmds.push_back(mk_req(REQ_SHRINK, 0, 0));
        // random phases over register settings
        for (int ph = 0; ph < 6; ph++) begin
            pending_cmds.push_back(mk_cfg(cfgs[ph]));
            for (int i = 0; i < 180; i++) begin
                idx = $urandom_range(0, 99);
                if (idx < 50)
                    pending_cmds.push_back(mk_req(REQ_ALLOC, 0, 0));
                else if (idx < 85) begin
                    // live marks a free of an object that is currently handed out
                    lc = mk_req(REQ_FREE, 15, 63);
                    lc.live = 1'b1;
                    pending_cmds.push_back(lc);
                end
                else if (idx < 93)
                    pending_cmds.push_back(mk_req(REQ_FREE, $urandom_range(0, 15),
                                                  $urandom_range(0, 63)));
                else if (idx < 98)
                    pending_cmds.push_back(mk_req(REQ_SHRINK, 0, 0));
                else
                    pending_cmds.push_back(mk_req(REQ_NONE, $urandom_range(0, 15),
                                                  $urandom_range(0, 63)));
            end
        end
        pending_cmds.push_back(mk_cfg(64));
    end

    // driver
    initial
    begin
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_type = '0;
        obj_slab = '0;
        obj_slot = '0;
        stim_done = 1'b0;
        gap = 0;
        errors = 0;
        for (int i = 0; i < SLABS; i++) begin
            m_state[i] = FR_UNOWNED;
            m_recent[i] = i[3:0];
            m_used[i] = 0;
            m_head[i] = 0;
        end
        m_opslab = 7'd64;
    end

    always @(posedge clk)
    begin
        cmd_t c;
        int k;
        bit wr_cfg;
        if (rst_n) begin
            wr_cfg = 1'b0;
            if (start && !busy) begin
                start <= 1'b0;
                gap = rand_gap();
            end else if (!start) begin
                if (gap > 0) begin
                    gap--;
                end else if (pending_cmds.size() != 0) begin
                    c = pending_cmds[0];
                    if (c.is_cfg) begin
                        // hold the write until the block is idle
                        if (expected_words.size() == 0 && !busy) begin
                            if (idle_cycles > 40) begin
                                void'(pending_cmds.pop_front());
                                wr_cfg = 1'b1;
                                cfg_wdata <= c.cfg_val;
                                m_opslab = c.cfg_val;
                                gap = 2;
                            end
                        end
                    end else begin
                        void'(pending_cmds.pop_front());
                        if (c.live) begin
                            c.live = 1'b0;
                            if (live_objs.size() != 0) begin
                                k = $urandom_range(0, live_objs.size() - 1);
                                c.fslab = SLAB_W'(live_objs[k] / SLOTS);
                                c.fslot = SLOT_W'(live_objs[k] % SLOTS);
                                live_objs.delete(k);
                            end
                        end
                        expected_words.push_back(predict_request(c));
                        start <= 1'b1;
                        req_type <= c.req;
                        obj_slab <= c.fslab;
                        obj_slot <= c.fslot;
                    end
                end else begin
                    stim_done = 1'b1;
                end
            end
            cfg_we <= wr_cfg;
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        result_t w;
        if (!rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (start && !busy) idle_cycles = 0;
            if (done) begin
                idle_cycles = 0;
                if (expected_words.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    w = expected_words.pop_front();
                    if (status !== w.st)
                        report_mismatch($sformatf("status %0d, expected %0d", status, w.st));
                    if (slab_index !== w.slab)
                        report_mismatch($sformatf("slab_index %0d, expected %0d",
                                                  slab_index, w.slab));
                    if (slot_index !== w.slot)
                        report_mismatch($sformatf("slot_index %0d, expected %0d",
                                                  slot_index, w.slot));
                    if (released_count !== w.rel)
                        report_mismatch($sformatf("released_count %0d, expected %0d",
                                                  released_count, w.rel));
                end
            end
            if (stim_done && expected_words.size() == 0 && !start && idle_cycles > 200) begin
                if (errors == 0)
                    $display("slab_object_allocator test passed");
                else
                    $display("slab_object_allocator test failed");
                $finish;
            end else if (idle_cycles > 2000) begin
                $display("slab_object_allocator test failed");
                $finish;
            end
        end
    end

endmodule
